// File: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on an explicit clock, off while reset is low
`define FQP_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property on the default clock and reset names
`define FQP_ASSERT(name, prop, msg) \
  `FQP_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

// File: src/fqp_pkg.sv
package fqp_pkg;

  // default queue depth
  localparam int unsigned DepthDef = 16;
  // fixed field widths
  localparam int unsigned HandleW = 8;
  localparam int unsigned OccW = 5;

  typedef enum logic [1:0] {
    ACT_ENQ   = 2'd0,
    ACT_DEQ   = 2'd1,
    ACT_PURGE = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DROPPED = 2'd1,
    ST_MISSING = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         action;
    logic [HandleW-1:0] item_handle;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic [HandleW-1:0] out_handle;
    logic               is_empty;
    logic [OccW-1:0]    occupancy;
  } out_word_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic               enq;
    logic               rem;
    logic               key_valid;
    logic [HandleW-1:0] key;
  } cell_ctrl_t;

endpackage

// File: src/fqp_cell.sv
module fqp_cell #(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                        clk_i,
  input  fqp_pkg::cell_ctrl_t         ctrl_i,
  input  logic [CntW-1:0]             count_i,
  input  logic [fqp_pkg::HandleW-1:0] next_entry_i,
  input  logic                        carry_i,
  output logic                        carry_o,
  output logic [fqp_pkg::HandleW-1:0] entry_o
);
  import fqp_pkg::*;

  logic [HandleW-1:0] entry_q;
  logic [HandleW-1:0] entry_d;
  logic               occupied;
  logic               match;

  // slot holds a live word when its index is below the fill level
  assign occupied = CntW'(Idx) < count_i;
  assign match    = occupied && ctrl_i.key_valid && (entry_q == ctrl_i.key);

  // removal point ripples toward the tail
  assign carry_o = carry_i | match;

  // shift from the neighbor at and past the removal point, or take a new tail word
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.rem && carry_o) begin
      entry_d = next_entry_i;
    end else if (ctrl_i.enq && (count_i == CntW'(Idx))) begin
      entry_d = ctrl_i.key;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: src/fifo_queue_with_purge.sv
// channel | direction | handshake             | word
// in      | input     | in_valid_i/in_stall_o   | in_word_i  (action, item_handle)
// out     | output    | out_valid_o/out_stall_i | out_word_o (status, handle, empty, occupancy)
// One word is taken per cycle unless in stalls; its result is in the output register next cycle.
// The rate is set by the cell row: every cell compares and shifts in the same cycle.
// Input stalls only while a finished result waits in the output register and out is stalled.
// Reset clears the fill count and the output valid; cell contents are left as they are.
module fifo_queue_with_purge #(
  parameter int unsigned DEPTH = fqp_pkg::DepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fqp_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output fqp_pkg::out_word_t out_word_o
);
  import fqp_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    count_d;
  logic               out_valid_q;
  out_word_t          out_q;
  out_word_t          out_d;
  logic               accept;
  logic               full;
  logic               empty;
  logic               key_nz;
  logic               enq_ok;
  logic               deq_ok;
  logic               purge_ok;
  logic               is_deq;
  status_e            status;
  cell_ctrl_t         ctrl;
  logic [DEPTH:0]     carry;
  logic [HandleW-1:0] ent [DEPTH];

  // handshake
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  assign full   = count_q == CntW'(DEPTH);
  assign empty  = count_q == '0;
  assign key_nz = in_word_i.item_handle != '0;

  // action decode
  always_comb begin
    is_deq   = 1'b0;
    enq_ok   = 1'b0;
    deq_ok   = 1'b0;
    purge_ok = 1'b0;
    status   = ST_DONE;
    unique case (action_e'(in_word_i.action))
      ACT_ENQ: begin
        enq_ok = accept && key_nz && !full;
        status = (key_nz && !full) ? ST_DONE : ST_DROPPED;
      end
      ACT_DEQ: begin
        is_deq = 1'b1;
        deq_ok = accept && !empty;
        status = empty ? ST_MISSING : ST_DONE;
      end
      ACT_PURGE: begin
        purge_ok = accept && carry[DEPTH];
        status   = carry[DEPTH] ? ST_DONE : ST_MISSING;
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  // broadcast controls; dequeue forces the removal point to the head
  assign ctrl.enq       = enq_ok;
  assign ctrl.rem       = deq_ok || purge_ok;
  assign ctrl.key_valid = key_nz && !is_deq;
  assign ctrl.key       = in_word_i.item_handle;
  assign carry[0]       = is_deq;

  // row of cells, each but the last shifting from its tail-side neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [HandleW-1:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = ent[i];
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    fqp_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .next_entry_i (nxt),
      .carry_i      (carry[i]),
      .carry_o      (carry[i+1]),
      .entry_o      (ent[i])
    );
  end

  // fill level
  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CntW'(1);
    end else if (deq_ok || purge_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  // result word
  always_comb begin
    out_d.status = status;
    if (deq_ok) begin
      out_d.out_handle = ent[0];
    end else if (purge_ok) begin
      out_d.out_handle = in_word_i.item_handle;
    end else begin
      out_d.out_handle = '0;
    end
    out_d.is_empty  = count_d == '0;
    out_d.occupancy = OccW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: src/fqp_checker.sv
`include "assert_macros.svh"

module fqp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input fqp_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input fqp_pkg::out_word_t out_word_o
);
  import fqp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // every accepted word shows a result on the next cycle
  `FQP_ASSERT(a_result_follows, in_acc |=> out_valid_o, "accepted word gave no result")

  // a stalled result holds
  `FQP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o), "stalled result changed")

  // empty flag agrees with occupancy
  `FQP_ASSERT(a_empty_occ, out_valid_o |-> (out_word_o.is_empty == (out_word_o.occupancy == '0)), "empty flag and occupancy disagree")

  // null handle enqueue is always dropped
  `FQP_ASSERT(a_null_drop, in_acc && (in_word_i.action == ACT_ENQ) && (in_word_i.item_handle == '0) |=> out_word_o.status == ST_DROPPED, "null enqueue not dropped")

endmodule

bind fifo_queue_with_purge fqp_checker u_fqp_checker (.*);
